// File: hdl/tds_pkg.sv
// shared types, codes and helpers for the tuple dedup stack
package tds_pkg;

  localparam int TERM_W     = 64;
  localparam int PRED_W     = 32;
  localparam int ARITY_W    = 3;
  localparam int LEVEL_W    = 7;
  localparam int ITEM_TERMS = 4;

  localparam logic [1:0] ACT_CHECK = 2'd0;
  localparam logic [1:0] ACT_PUSH  = 2'd1;
  localparam logic [1:0] ACT_MARK  = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic [PRED_W-1:0]  pred_id;
    logic [ARITY_W-1:0] arity;
    logic [TERM_W-1:0]  term_0;
    logic [TERM_W-1:0]  term_1;
    logic [TERM_W-1:0]  term_2;
    logic [TERM_W-1:0]  term_3;
    logic [LEVEL_W-1:0] mark_value;
  } in_t;

  typedef struct packed {
    logic               redundant;
    logic               full_error;
    logic [LEVEL_W-1:0] fill_level;
  } out_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic req_check;
    logic hit;
    logic scan_end;
  } sts_t;

  // terms past the fourth read as zero
  function automatic logic [TERM_W-1:0] item_term(input in_t r, input int j);
    logic [TERM_W-1:0] t;
    t = '0;
    unique case (j)
      0:       t = r.term_0;
      1:       t = r.term_1;
      2:       t = r.term_2;
      3:       t = r.term_3;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

// File: hdl/tds_ctrl.sv
// controller state machine for the tuple dedup stack
module tds_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  tds_pkg::sts_t sts,
  output tds_pkg::cmd_t cmd,
  output logic          busy
);

  tds_pkg::state_t state;
  tds_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tds_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tds_pkg::ST_IDLE: begin
        if (start && sts.req_check) begin
          state_next = tds_pkg::ST_SCAN;
        end
      end
      tds_pkg::ST_SCAN: begin
        if (sts.hit || sts.scan_end) begin
          state_next = tds_pkg::ST_IDLE;
        end
      end
      default: state_next = tds_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd    = '0;
    busy   = 1'b0;
    unique case (state)
      tds_pkg::ST_IDLE: begin
        cmd.accept = start;
      end
      tds_pkg::ST_SCAN: begin
        busy       = 1'b1;
        cmd.scan   = 1'b1;
        cmd.finish = sts.hit || sts.scan_end;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

// File: hdl/tds_dp.sv
// datapath of the tuple dedup stack: entry memory, fill level, scan and compare
module tds_dp #(
  parameter int CAPACITY  = 64,
  parameter int MAX_ARITY = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  tds_pkg::in_t  req,
  input  tds_pkg::cmd_t cmd,
  output tds_pkg::sts_t sts,
  output logic          done,
  output tds_pkg::out_t result
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int FW = $clog2(CAPACITY + 1);

  logic [tds_pkg::PRED_W-1:0]                   mem_pred  [CAPACITY];
  logic [tds_pkg::ARITY_W-1:0]                  mem_arity [CAPACITY];
  logic [MAX_ARITY-1:0][tds_pkg::TERM_W-1:0]    mem_terms [CAPACITY];

  tds_pkg::in_t                                 item;
  logic [FW-1:0]                                fill;
  logic [FW-1:0]                                fill_next;
  logic [FW-1:0]                                addr;
  logic                                         rvalid;
  logic [tds_pkg::PRED_W-1:0]                   rd_pred;
  logic [tds_pkg::ARITY_W-1:0]                  rd_arity;
  logic [MAX_ARITY-1:0][tds_pkg::TERM_W-1:0]    rd_terms;

  logic                                         is_full;
  logic                                         push_ok;
  logic                                         rd_en;
  logic [tds_pkg::ARITY_W-1:0]                  push_arity;
  logic [MAX_ARITY-1:0][tds_pkg::TERM_W-1:0]    push_terms;
  logic [FW-1:0]                                mark_clamped;
  logic [MAX_ARITY-1:0]                         term_eq;

  assign is_full  = fill >= FW'(CAPACITY);
  assign push_ok  = cmd.accept && (req.action == tds_pkg::ACT_PUSH) && !is_full;
  assign rd_en    = cmd.scan && !cmd.finish && (addr < fill);

  assign push_arity = ({1'b0, req.arity} > 4'(MAX_ARITY)) ?
                      tds_pkg::ARITY_W'(MAX_ARITY) : req.arity;

  assign mark_clamped = ({25'b0, req.mark_value} > 32'(CAPACITY)) ?
                        FW'(CAPACITY) : FW'(req.mark_value);

  always_comb begin
    for (int j = 0; j < MAX_ARITY; j++) begin
      push_terms[j] = tds_pkg::item_term(req, j);
    end
  end

  // term j only counts below the stored arity
  always_comb begin
    for (int j = 0; j < MAX_ARITY; j++) begin
      term_eq[j] = (32'(j) >= 32'(rd_arity)) ||
                   (rd_terms[j] == tds_pkg::item_term(item, j));
    end
  end

  assign sts.req_check = req.action == tds_pkg::ACT_CHECK;
  assign sts.hit       = rvalid && (rd_pred == item.pred_id) && (&term_eq);
  assign sts.scan_end  = (addr >= fill) && !rvalid;

  always_comb begin
    fill_next = fill;
    if (push_ok) begin
      fill_next = fill + FW'(1);
    end else if (cmd.accept && (req.action == tds_pkg::ACT_MARK)) begin
      fill_next = mark_clamped;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_pred[fill[AW-1:0]]  <= req.pred_id;
      mem_arity[fill[AW-1:0]] <= push_arity;
      mem_terms[fill[AW-1:0]] <= push_terms;
    end
    if (rd_en) begin
      rd_pred  <= mem_pred[addr[AW-1:0]];
      rd_arity <= mem_arity[addr[AW-1:0]];
      rd_terms <= mem_terms[addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      addr   <= '0;
      rvalid <= 1'b0;
      done   <= 1'b0;
    end else begin
      fill <= fill_next;
      done <= (cmd.accept && !sts.req_check) || cmd.finish;
      if (cmd.accept) begin
        addr   <= '0;
        rvalid <= 1'b0;
      end else if (cmd.scan) begin
        rvalid <= rd_en;
        if (rd_en) begin
          addr <= addr + FW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.redundant  <= 1'b1 & sts.hit;
      result.full_error <= 1'b0;
      result.fill_level <= tds_pkg::LEVEL_W'(fill);
    end else if (cmd.accept) begin
      result.redundant  <= 1'b0;
      result.full_error <= (req.action == tds_pkg::ACT_PUSH) && is_full;
      result.fill_level <= tds_pkg::LEVEL_W'(fill_next);
    end
  end

endmodule

// File: hdl/tuple_dedup_stack.sv
// top level of the tuple dedup stack
// push, set-mark and unknown requests: result strobe in the cycle after acceptance, busy stays low
// check request: busy while the stored entries are scanned one per cycle from the bottom;
//   result is registered when the scan passes the fill level, or earlier when a matching entry is found
// no new request is taken until a check's scan has finished; otherwise one request per cycle
// reset is synchronous, active high: clears the fill level and control; entries are kept
module tuple_dedup_stack #(
  parameter int CAPACITY  = 64,
  parameter int MAX_ARITY = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  tds_pkg::in_t  req,
  output logic          done,
  output tds_pkg::out_t result
);

  tds_pkg::cmd_t cmd;
  tds_pkg::sts_t sts;

  tds_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  tds_dp #(
    .CAPACITY  (CAPACITY),
    .MAX_ARITY (MAX_ARITY)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .sts    (sts),
    .done   (done),
    .result (result)
  );

endmodule

// File: hdl/tds_checker.sv
// port-level checker for the tuple dedup stack, bound to the top level
module tds_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input tds_pkg::in_t  req,
  input logic          done,
  input tds_pkg::out_t result
);

  // reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !busy && !done)
    else $error("busy or done after reset");

  // non-check requests complete in the cycle after acceptance without going busy
  a_quick_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (req.action != tds_pkg::ACT_CHECK) |=> done && !busy)
    else $error("missing one-cycle result");

  // a check request always occupies the scan
  a_check_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (req.action == tds_pkg::ACT_CHECK) |=> busy && !done)
    else $error("check did not start scanning");

  // a result never carries both flags
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.redundant && result.full_error))
    else $error("redundant and full_error both set");

endmodule

bind tuple_dedup_stack tds_checker u_chk (.*);

// File: test/tb.sv
// self-checking testbench for the tuple dedup stack
`timescale 1ns / 100ps

module tb;

  localparam int CAPACITY      = 64;
  localparam int MAX_ARITY     = 4;
  localparam int SETTLE_CYCLES = CAPACITY + 6;
  localparam int CYCLE_LIMIT   = 1000000;

  localparam logic [1:0]                 ACT_NONE = 2'd3;
  localparam logic [tds_pkg::TERM_W-1:0] ONES     = '1;
  localparam logic [tds_pkg::TERM_W-1:0] T_A      = 64'h0123_4567_89ab_cdef;
  localparam logic [tds_pkg::TERM_W-1:0] T_B      = 64'hfedc_ba98_7654_3210;
  localparam logic [tds_pkg::TERM_W-1:0] T_C      = 64'h8000_0000_0000_0001;
  localparam logic [tds_pkg::TERM_W-1:0] T_D      = 64'h5a5a_a5a5_0f0f_f0f0;

  logic          clk;
  logic          rst;
  logic          start;
  logic          busy;
  tds_pkg::in_t  req;
  logic          done;
  tds_pkg::out_t result;

  tuple_dedup_stack #(
    .CAPACITY(CAPACITY),
    .MAX_ARITY(MAX_ARITY)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .done(done),
    .result(result)
  );

  // predicted stack contents
  logic [tds_pkg::PRED_W-1:0]  stack_pred    [CAPACITY];
  logic [tds_pkg::ARITY_W-1:0] stack_arity   [CAPACITY];
  logic [tds_pkg::TERM_W-1:0]  stack_terms   [CAPACITY][MAX_ARITY];
  bit                          stack_written [CAPACITY];
  int                          stack_fill  = 0;
  int                          idle_pct    = 0;
  int                          fail_count  = 0;
  int                          cycle_count = 0;
  tds_pkg::out_t               expected_results [$];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin : check_results
    tds_pkg::out_t want;
    if (!rst && done !== 1'b0) begin
      if (expected_results.size() == 0) begin
        $error("result with no request pending: %p", result);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (result.redundant !== want.redundant) begin
          $error("redundant: expected %0d, got %0d", want.redundant, result.redundant);
          fail_count++;
        end
        if (result.full_error !== want.full_error) begin
          $error("full_error: expected %0d, got %0d", want.full_error, result.full_error);
          fail_count++;
        end
        if (result.fill_level !== want.fill_level) begin
          $error("fill_level: expected %0d, got %0d", want.fill_level, result.fill_level);
          fail_count++;
        end
      end
    end
  end

  // apply one accepted request to the stack model and queue its result
  function automatic void update_stack_model(input tds_pkg::in_t r);
    tds_pkg::out_t              o;
    logic [tds_pkg::TERM_W-1:0] t [tds_pkg::ITEM_TERMS];
    int                         n;
    bit                         same;
    o = '0;
    t[0] = r.term_0;
    t[1] = r.term_1;
    t[2] = r.term_2;
    t[3] = r.term_3;
    case (r.action)
      tds_pkg::ACT_CHECK: begin
        for (int i = 0; i < stack_fill; i++) begin
          if (stack_pred[i] == r.pred_id) begin
            same = 1'b1;
            for (int j = 0; j < int'(stack_arity[i]); j++)
              if (stack_terms[i][j] != t[j]) same = 1'b0;
            if (same) o.redundant = 1'b1;
          end
        end
      end
      tds_pkg::ACT_PUSH: begin
        if (stack_fill >= CAPACITY) begin
          o.full_error = 1'b1;
        end else begin
          n = (r.arity > MAX_ARITY) ? MAX_ARITY : int'(r.arity);
          stack_pred[stack_fill]    = r.pred_id;
          stack_arity[stack_fill]   = tds_pkg::ARITY_W'(n);
          stack_written[stack_fill] = 1'b1;
          for (int j = 0; j < n; j++) stack_terms[stack_fill][j] = t[j];
          stack_fill++;
        end
      end
      tds_pkg::ACT_MARK: begin
        stack_fill = (r.mark_value > CAPACITY) ? CAPACITY : int'(r.mark_value);
      end
      default: begin
      end
    endcase
    o.fill_level = tds_pkg::LEVEL_W'(stack_fill);
    expected_results.insert(expected_results.size(), o);
  endfunction

  // number of entries written without a gap from the bottom
  function automatic int written_depth();
    for (int i = 0; i < CAPACITY; i++)
      if (!stack_written[i]) return i;
    return CAPACITY;
  endfunction

  function automatic tds_pkg::in_t make_request(input logic [1:0] action,
                                                input logic [tds_pkg::PRED_W-1:0] pred,
                                                input logic [tds_pkg::ARITY_W-1:0] arity,
                                                input logic [tds_pkg::TERM_W-1:0] t0,
                                                input logic [tds_pkg::TERM_W-1:0] t1,
                                                input logic [tds_pkg::TERM_W-1:0] t2,
                                                input logic [tds_pkg::TERM_W-1:0] t3,
                                                input logic [tds_pkg::LEVEL_W-1:0] mark);
    tds_pkg::in_t r;
    r.action     = action;
    r.pred_id    = pred;
    r.arity      = arity;
    r.term_0     = t0;
    r.term_1     = t1;
    r.term_2     = t2;
    r.term_3     = t3;
    r.mark_value = mark;
    return r;
  endfunction

  function automatic logic [tds_pkg::TERM_W-1:0] random_term();
    case ($urandom_range(0, 3))
      0:       return tds_pkg::TERM_W'($urandom_range(0, 3));
      1:       return ONES;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic tds_pkg::in_t random_request();
    tds_pkg::in_t               r;
    logic [tds_pkg::TERM_W-1:0] t [tds_pkg::ITEM_TERMS];
    int                         sel;
    int                         idx;
    int                         j;
    // start from noise in every field, then shape most requests
    r.action     = 2'($urandom_range(0, 3));
    r.pred_id    = $urandom;
    r.arity      = tds_pkg::ARITY_W'($urandom_range(0, 7));
    r.mark_value = tds_pkg::LEVEL_W'($urandom_range(0, 127));
    for (int k = 0; k < tds_pkg::ITEM_TERMS; k++) t[k] = {$urandom, $urandom};
    sel = $urandom_range(0, 99);
    if (sel < 36) begin
      r.action = tds_pkg::ACT_CHECK;
      if (stack_fill > 0 && $urandom_range(0, 99) < 65) begin
        // look up a stored tuple, sometimes with one term disturbed
        idx = $urandom_range(0, stack_fill - 1);
        r.pred_id = stack_pred[idx];
        for (int k = 0; k < int'(stack_arity[idx]); k++) t[k] = stack_terms[idx][k];
        if (stack_arity[idx] != 0 && $urandom_range(0, 99) < 30) begin
          j = $urandom_range(0, int'(stack_arity[idx]) - 1);
          t[j][$urandom_range(0, tds_pkg::TERM_W - 1)] ^= 1'b1;
        end
      end else begin
        r.pred_id = tds_pkg::PRED_W'($urandom_range(0, 3));
        for (int k = 0; k < tds_pkg::ITEM_TERMS; k++) t[k] = random_term();
      end
    end else if (sel < 74) begin
      r.action = tds_pkg::ACT_PUSH;
      if ($urandom_range(0, 99) < 70) r.pred_id = tds_pkg::PRED_W'($urandom_range(0, 3));
      if ($urandom_range(0, 99) < 88) r.arity = tds_pkg::ARITY_W'($urandom_range(0, MAX_ARITY));
      for (int k = 0; k < tds_pkg::ITEM_TERMS; k++) t[k] = random_term();
    end else if (sel < 92) begin
      r.action = tds_pkg::ACT_MARK;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: r.mark_value = tds_pkg::LEVEL_W'($urandom_range(0, stack_fill));
        5, 6:          r.mark_value = tds_pkg::LEVEL_W'($urandom_range(0, written_depth()));
        7:             r.mark_value = tds_pkg::LEVEL_W'($urandom_range(0, CAPACITY));
        default:       r.mark_value = tds_pkg::LEVEL_W'($urandom_range(CAPACITY, 127));
      endcase
    end else if (sel < 96) begin
      r.action = ACT_NONE;
    end
    r.term_0 = t[0];
    r.term_1 = t[1];
    r.term_2 = t[2];
    r.term_3 = t[3];
    // a scan must never reach an entry that was never written
    if (r.action == tds_pkg::ACT_CHECK && stack_fill > written_depth()) begin
      r.action     = tds_pkg::ACT_MARK;
      r.mark_value = tds_pkg::LEVEL_W'($urandom_range(0, written_depth()));
    end
    return r;
  endfunction

  // start stays high after acceptance; the next call lowers it or replaces the request, and a drain lowers it
  task automatic send_request(input tds_pkg::in_t r);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk) start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy !== 1'b0);
    update_stack_model(r);
  endtask

  task automatic wait_for_results();
    @(negedge clk) start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_push_and_check();
    idle_pct = 0;
    send_request(make_request(tds_pkg::ACT_PUSH, '0, 3'd0, '0, '0, '0, '0, '0));
    send_request(make_request(tds_pkg::ACT_PUSH, '1, 3'd4, ONES, ONES, ONES, ONES, '0));
    // arity above the maximum saturates
    send_request(make_request(tds_pkg::ACT_PUSH, 32'd5, 3'd7, T_A, T_B, T_C, T_D, 7'd127));
    send_request(make_request(tds_pkg::ACT_PUSH, 32'd1, 3'd2, '0, ONES, 64'd7, 64'd9, '0));
    send_request(make_request(tds_pkg::ACT_CHECK, '1, 3'd4, ONES, ONES, ONES, ONES, '0));
    send_request(make_request(tds_pkg::ACT_CHECK, '1, 3'd4, ONES, ONES, ONES, ~64'd1, '0));
    // arity zero entry matches any terms
    send_request(make_request(tds_pkg::ACT_CHECK, '0, 3'd7, T_D, T_C, T_B, T_A, 7'd127));
    send_request(make_request(tds_pkg::ACT_CHECK, 32'd5, 3'd0, T_A, T_B, T_C, T_D, '0));
    // only the entry's first two terms count
    send_request(make_request(tds_pkg::ACT_CHECK, 32'd1, 3'd1, '0, ONES, 64'd123, 64'd456, '0));
    send_request(make_request(tds_pkg::ACT_CHECK, 32'd2, 3'd4, '0, '0, '0, '0, '0));
    send_request(make_request(ACT_NONE, '1, 3'd7, ONES, ONES, ONES, ONES, 7'd127));
    wait_for_results();
  endtask

  task automatic test_marks_and_full();
    idle_pct = 0;
    send_request(make_request(tds_pkg::ACT_MARK, '0, '0, '0, '0, '0, '0, 7'd2));
    send_request(make_request(tds_pkg::ACT_CHECK, 32'd5, 3'd4, T_A, T_B, T_C, T_D, '0));
    // raise past the written entries to a full stack, then push into it
    send_request(make_request(tds_pkg::ACT_MARK, '0, '0, '0, '0, '0, '0, 7'd64));
    send_request(make_request(tds_pkg::ACT_PUSH, '1, 3'd4, ONES, ONES, ONES, ONES, 7'd127));
    send_request(make_request(tds_pkg::ACT_MARK, '1, 3'd7, ONES, ONES, ONES, ONES, 7'd127));
    send_request(make_request(tds_pkg::ACT_PUSH, 32'd9, 3'd1, T_A, '0, '0, '0, '0));
    send_request(make_request(tds_pkg::ACT_MARK, '0, '0, '0, '0, '0, '0, 7'd0));
    send_request(make_request(tds_pkg::ACT_CHECK, '0, 3'd0, '0, '0, '0, '0, '0));
    send_request(make_request(tds_pkg::ACT_MARK, '0, '0, '0, '0, '0, '0, 7'd4));
    send_request(make_request(tds_pkg::ACT_CHECK, 32'd1, 3'd2, '0, ONES, '0, '0, '0));
    send_request(make_request(tds_pkg::ACT_PUSH, 32'd3, 3'd3, T_D, T_C, T_B, T_A, 7'd127));
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int count, input int idle);
    idle_pct = idle;
    repeat (count) send_request(random_request());
    wait_for_results();
  endtask

  task automatic test_pause_for_results();
    idle_pct = 0;
    repeat (4) begin
      repeat (6) send_request(random_request());
      wait_for_results();
    end
  endtask

  initial begin
    rst   = 1'b1;
    start = 1'b0;
    req   = '0;
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    test_push_and_check();
    test_marks_and_full();
    test_random_traffic(330, 9);
    test_random_traffic(330, 85);
    test_random_traffic(330, 0);
    test_pause_for_results();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
